// ===== rtl/core/sagl_pkg.sv =====
package sagl_pkg;

    // Command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_ROTATION_RATE  = 2'd0;
    localparam logic [1:0] CFG_HALF_WIDTH     = 2'd1;
    localparam logic [1:0] CFG_ANGLE_STEP     = 2'd2;
    localparam logic [1:0] CFG_ENTRIES_IN_USE = 2'd3;

    // Configuration reset values
    localparam logic [15:0] RATE_RESET    = 16'd0;
    localparam logic [14:0] HWIDTH_RESET  = 15'd8192;
    localparam logic [14:0] STEP_RESET    = 15'd64;
    localparam logic [10:0] ENTRIES_RESET = 11'd256;

    // Shared divider geometry: quotient bits and dividend width
    localparam int unsigned DIV_QBITS = 17;
    localparam int unsigned DIV_NBITS = 33;

    typedef struct packed {
        logic [1:0]         command;
        logic [15:0]        time_delta;
        logic [15:0]        aim_angle;
        logic [9:0]         entry_index;
        logic signed [15:0] entry_value;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] gain;
        logic [15:0]        scan_angle;
        logic               in_beam;
    } t_out_beat;

    typedef struct packed {
        logic                 start;
        logic [DIV_NBITS-1:0] dividend;
        logic [15:0]          divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_QBITS-1:0] quot;
        logic [15:0]          rem;
    } t_div_stat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK,
        ST_ADVANCE,
        ST_WRITE,
        ST_CHECK,
        ST_DIV1,
        ST_FETCH0,
        ST_FETCH1,
        ST_MUL,
        ST_DIV2,
        ST_WAIT2,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/core/sagl_div.sv =====
module sagl_div
    import sagl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_req  i_req,
    output t_div_stat o_stat
);

    logic [15:0]          r_rem;
    logic [DIV_QBITS-1:0] r_q;
    logic [15:0]          r_div;
    logic [4:0]           r_cnt;
    logic                 r_done;

    logic [16:0] trial;
    logic        ge;

    assign trial = {r_rem, r_q[DIV_QBITS-1]};
    assign ge    = trial >= {1'b0, r_div};

    // Restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_cnt  <= 5'(DIV_QBITS);
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == 5'd1);
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.dividend[DIV_QBITS+15:DIV_QBITS];
            r_q   <= i_req.dividend[DIV_QBITS-1:0];
            r_div <= i_req.divisor;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? 16'(trial - {1'b0, r_div}) : trial[15:0];
            r_q   <= {r_q[DIV_QBITS-2:0], ge};
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.quot = r_q;
    assign o_stat.rem  = r_rem;

endmodule

// ===== rtl/core/sagl_table.sv =====
module sagl_table #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic signed [15:0] i_wdata,
    input  logic [AW-1:0]      i_raddr,
    output logic signed [15:0] o_rdata
);

    logic signed [15:0] r_mem [DEPTH];
    logic signed [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/scanning_antenna_gain_lookup_unit.sv =====
// From the accepting edge: a query makes two passes through the shared divider,
// two table reads and one multiply, and stops after the first pass if past the
// table; a tick multiplies, then advances the angle; a write, a query outside
// the beam or an idle command goes straight to the result. One beat at a time:
// input stalls while the output is full and reopens the cycle after the load.
// Reset (i_rst_n low, synchronous): angle to zero, registers to defaults.
module scanning_antenna_gain_lookup_unit
    import sagl_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 1024,
    parameter int unsigned ANGLE_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,

    input  logic        i_in_valid,
    input  t_in_beat    i_in_data,
    output logic        o_in_stall,

    output logic        o_out_valid,
    output t_out_beat   o_out_data,
    input  logic        i_out_stall
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned IW = (AW > 10) ? AW : 10;
    localparam int unsigned DW = ((ANGLE_BITS > 16) ? ANGLE_BITS : 16) + 1;

    // Configuration registers
    logic [15:0] r_rate;
    logic [14:0] r_hwidth;
    logic [14:0] r_step;
    logic [10:0] r_entries;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate    <= RATE_RESET;
            r_hwidth  <= HWIDTH_RESET;
            r_step    <= STEP_RESET;
            r_entries <= ENTRIES_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROTATION_RATE:  r_rate    <= i_cfg_data;
                CFG_HALF_WIDTH:     r_hwidth  <= i_cfg_data[14:0];
                CFG_ANGLE_STEP:     r_step    <= i_cfg_data[14:0];
                CFG_ENTRIES_IN_USE: r_entries <= i_cfg_data[10:0];
                default:            r_rate    <= r_rate;
            endcase
        end
    end

    // Sequencer and datapath registers
    t_state r_state, n_state;

    t_in_beat                r_in;
    logic [ANGLE_BITS-1:0]   r_angle;
    logic signed [34:0]      r_prod;
    logic [AW-1:0]           r_k;
    logic [15:0]             r_t;
    logic signed [15:0]      r_y1;
    logic                    r_neg;
    logic signed [15:0]      r_gain;
    logic                    r_hit;
    logic                    r_out_valid;
    t_out_beat               r_out;

    logic in_accept;
    logic out_free;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Shared divider
    t_div_req  div_req;
    t_div_stat div_stat;

    sagl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_stat  (div_stat)
    );

    // Pattern table
    logic               tbl_we;
    logic [AW-1:0]      tbl_waddr;
    logic [AW-1:0]      tbl_raddr;
    logic signed [15:0] tbl_rdata;
    logic [IW-1:0]      widx_ext;

    assign widx_ext  = IW'(r_in.entry_index);
    assign tbl_waddr = widx_ext[AW-1:0];

    sagl_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (r_in.entry_value),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    // Query geometry: offset into the pattern, measured from its left edge
    logic signed [DW-1:0] diff_ang;
    logic signed [DW-1:0] hw_ext;
    logic signed [DW-1:0] off;
    logic                 in_range;
    logic [16:0]          k_full;
    logic [16:0]          eff_count;
    logic [16:0]          t_full;

    assign diff_ang = $signed(DW'(r_in.aim_angle)) - $signed(DW'(r_angle));
    assign hw_ext   = $signed(DW'(r_hwidth));
    assign off      = diff_ang + hw_ext;
    assign in_range = (r_step != '0) && (diff_ang > -hw_ext) && (diff_ang < hw_ext);

    // Entry count, capped at the table depth
    assign eff_count = (17'(r_entries) > 17'(TABLE_DEPTH)) ? 17'(TABLE_DEPTH)
                                                            : 17'(r_entries);
    // k = ceil(off / step) = floor((off - 1) / step) + 1, t = rem + 1
    assign k_full = div_stat.quot + 17'd1;
    assign t_full = {1'b0, div_stat.rem} + 17'd1;

    // Shared multiplier: rate * delta on a tick, slope * t on a query
    logic signed [16:0] slope;
    logic signed [17:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [34:0] mul_p;

    assign slope = {tbl_rdata[15], tbl_rdata} - {r_y1[15], r_y1};
    assign mul_a = (r_state == ST_MUL) ? {slope[16], slope} : {2'b00, r_rate};
    assign mul_b = (r_state == ST_MUL) ? {1'b0, r_t} : {1'b0, r_in.time_delta};
    assign mul_p = mul_a * mul_b;

    // Rounding divide: floor((2*num + step) / (2*step)); for a negative
    // numerator floor(N/D) = ~floor(~N/D)
    logic signed [35:0] rnd_num;
    logic [35:0]        rnd_mag;
    logic [17:0]        q_signed;

    assign rnd_num  = {r_prod, 1'b0} + 36'(r_step);
    assign rnd_mag  = rnd_num[35] ? ~rnd_num : rnd_num;
    assign q_signed = r_neg ? ~{1'b0, div_stat.quot} : {1'b0, div_stat.quot};

    // Next state and control
    always_comb begin
        n_state          = r_state;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        tbl_we           = 1'b0;
        tbl_raddr        = r_k;

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    unique case (i_in_data.command)
                        CMD_TICK:  n_state = ST_TICK;
                        CMD_QUERY: n_state = ST_CHECK;
                        CMD_WRITE: n_state = ST_WRITE;
                        CMD_NONE:  n_state = ST_DONE;
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_TICK:    n_state = ST_ADVANCE;
            ST_ADVANCE: n_state = ST_DONE;
            ST_WRITE: begin
                // drop writes past the table
                tbl_we  = ({1'b0, widx_ext} < (IW + 1)'(TABLE_DEPTH));
                n_state = ST_DONE;
            end
            ST_CHECK: begin
                if (in_range) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_NBITS'(off[15:0] - 16'd1);
                    div_req.divisor  = {1'b0, r_step};
                    n_state          = ST_DIV1;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DIV1: begin
                // fetch the left neighbor as soon as k is known
                tbl_raddr = div_stat.quot[AW-1:0];
                if (div_stat.done) begin
                    n_state = (k_full < eff_count) ? ST_FETCH0 : ST_DONE;
                end
            end
            ST_FETCH0: begin
                tbl_raddr = r_k;
                n_state   = ST_FETCH1;
            end
            ST_FETCH1: n_state = ST_MUL;
            ST_MUL:    n_state = ST_DIV2;
            ST_DIV2: begin
                div_req.start    = 1'b1;
                div_req.dividend = rnd_mag[DIV_NBITS-1:0];
                div_req.divisor  = {r_step, 1'b0};
                n_state          = ST_WAIT2;
            end
            ST_WAIT2: begin
                if (div_stat.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold the result until the output register frees up
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Antenna angle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
        end else if (r_state == ST_ADVANCE) begin
            r_angle <= r_angle + ANGLE_BITS'(r_prod[31:16]);
        end
    end

    // Datapath payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in   <= i_in_data;
            r_gain <= '0;
            r_hit  <= 1'b0;
        end
        if (r_state == ST_TICK || r_state == ST_MUL) begin
            r_prod <= mul_p;
        end
        if (r_state == ST_DIV1 && div_stat.done) begin
            r_k <= k_full[AW-1:0];
            r_t <= t_full[15:0];
        end
        // left neighbor arrives in the cycle after its address
        if (r_state == ST_FETCH0) begin
            r_y1 <= tbl_rdata;
        end
        if (r_state == ST_DIV2) begin
            r_neg <= rnd_num[35];
        end
        if (r_state == ST_WAIT2 && div_stat.done) begin
            r_gain <= r_y1 + q_signed[15:0];
            r_hit  <= 1'b1;
        end
    end

    // Output register: load on finish, drop valid once the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_out.gain       <= r_gain;
            r_out.scan_angle <= 16'(r_angle);
            r_out.in_beam    <= r_hit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== tb/tb_scanning_antenna_gain_lookup_unit.sv =====
`timescale 1ns / 1ps

module tb_scanning_antenna_gain_lookup_unit;
    import sagl_pkg::*;

    localparam int TABLE_DEPTH   = 1024;
    localparam int HOLD_CYCLES   = 300;     // long receiver hold-off, fills the block
    localparam int SETTLE_CYCLES = 60;      // longer than the slowest query
    localparam int CYCLE_LIMIT   = 600000;

    logic i_clk;
    logic i_rst_n = 1'b0;

    // Configuration port, driven only while the block is idle
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = CFG_ROTATION_RATE;
    logic [15:0] cfg_data  = '0;

    // Input and output channels
    logic      in_valid = 1'b0;
    t_in_beat  in_data  = '0;
    logic      in_taken = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_beat o_out_data;
    logic      out_stall = 1'b0;

    // Idle and stall rates of the current phase, in percent
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Long hold-off request from the stimulus, counted in its own process
    logic hold_req  = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;

    // Register shadows, written as the port writes them
    logic [15:0] cfg_rate    = RATE_RESET;
    logic [14:0] cfg_hw      = HWIDTH_RESET;
    logic [14:0] cfg_step    = STEP_RESET;
    logic [10:0] cfg_entries = ENTRIES_RESET;

    // Predicted block state, advanced on each accepted beat
    logic [15:0]        scan_angle = '0;
    logic signed [15:0] gain_table [TABLE_DEPTH];

    // Planning state of the stimulus: the angle as it will be once the
    // queued beats are taken, and which table entries will hold data
    logic [15:0] plan_angle = '0;
    bit          plan_written [TABLE_DEPTH];

    t_in_beat  pending_beats [$];
    t_out_beat gain_results_due [$];

    int errors      = 0;
    int cycle_count = 0;
    int n_ticks     = 0;
    int n_queries   = 0;
    int n_hits      = 0;
    int n_writes    = 0;
    int n_idle_cmds = 0;

    scanning_antenna_gain_lookup_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (out_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Turn the antenna by rate * delta, scaled by 2^-16, wrapping at a full turn
    function automatic logic [15:0] advance_angle(logic [15:0] angle, logic [15:0] delta);
        logic [31:0] prod;
        prod = 32'(cfg_rate) * 32'(delta);
        return angle + prod[31:16];
    endfunction

    // Find the upper table entry around the target; 0 when outside the beam,
    // past the table or with a zero step
    function automatic bit beam_slot(logic [15:0] angle, logic [15:0] target,
                                     output int k);
        int d;
        int hw;
        int st;
        int cnt;
        d   = int'(target) - int'(angle);
        hw  = int'(cfg_hw);
        st  = int'(cfg_step);
        cnt = (cfg_entries > TABLE_DEPTH) ? TABLE_DEPTH : int'(cfg_entries);
        k   = 0;
        if (st == 0 || d <= -hw || d >= hw)
            return 1'b0;
        k = (d + hw + st - 1) / st;
        return k < cnt;
    endfunction

    // Apply one accepted beat to the predicted state and return its result
    function automatic t_out_beat predict_lookup(t_in_beat b);
        t_out_beat r;
        int        k;
        longint    y1;
        longint    y2;
        longint    off;
        longint    t;
        longint    num2;
        longint    den;
        longint    q;
        r = '0;
        case (b.command)
            CMD_TICK: begin
                scan_angle = advance_angle(scan_angle, b.time_delta);
                n_ticks++;
            end
            CMD_WRITE: begin
                gain_table[b.entry_index] = b.entry_value;
                n_writes++;
            end
            CMD_QUERY: begin
                n_queries++;
                if (beam_slot(scan_angle, b.aim_angle, k)) begin
                    y1   = gain_table[k-1];
                    y2   = gain_table[k];
                    off  = longint'(b.aim_angle) - longint'(scan_angle)
                           + longint'(cfg_hw);
                    t    = off - longint'(k - 1) * longint'(cfg_step);
                    // round to nearest, halves toward plus infinity
                    num2 = 2 * (y2 - y1) * t + longint'(cfg_step);
                    den  = 2 * longint'(cfg_step);
                    q    = num2 / den;
                    if (num2 % den != 0 && num2 < 0)
                        q--;
                    r.gain    = 16'(y1 + q);
                    r.in_beam = 1'b1;
                    n_hits++;
                end
            end
            default: begin
                n_idle_cmds++;
            end
        endcase
        r.scan_angle = scan_angle;
        return r;
    endfunction

    // Stimulus helpers: every field starts random, then the command's own
    // fields are set
    function automatic t_in_beat random_beat(logic [1:0] cmd);
        t_in_beat b;
        b.command     = cmd;
        b.time_delta  = 16'($urandom);
        b.aim_angle   = 16'($urandom);
        b.entry_index = 10'($urandom);
        b.entry_value = 16'($urandom);
        return b;
    endfunction

    task automatic queue_tick(logic [15:0] delta);
        t_in_beat b;
        b            = random_beat(CMD_TICK);
        b.time_delta = delta;
        plan_angle   = advance_angle(plan_angle, delta);
        pending_beats.push_back(b);
    endtask

    task automatic queue_write(logic [9:0] idx, logic [15:0] value);
        t_in_beat b;
        b                 = random_beat(CMD_WRITE);
        b.entry_index     = idx;
        b.entry_value     = value;
        plan_written[idx] = 1'b1;
        pending_beats.push_back(b);
    endtask

    // Load any entry the query will interpolate from before the query itself
    task automatic queue_query(logic [15:0] target);
        t_in_beat b;
        int       k;
        if (beam_slot(plan_angle, target, k)) begin
            if (!plan_written[k-1])
                queue_write(10'(k - 1), 16'($urandom));
            if (!plan_written[k])
                queue_write(10'(k), 16'($urandom));
        end
        b           = random_beat(CMD_QUERY);
        b.aim_angle = target;
        pending_beats.push_back(b);
    endtask

    // Query at an offset from the lower beam edge of the planned angle
    task automatic query_at_offset(int off);
        queue_query(16'(int'(plan_angle) - int'(cfg_hw) + off));
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ROTATION_RATE: cfg_rate    = value;
            CFG_HALF_WIDTH:    cfg_hw      = value[14:0];
            CFG_ANGLE_STEP:    cfg_step    = value[14:0];
            default:           cfg_entries = value[10:0];
        endcase
    endtask

    // Drain the block, settle, then load a new register setting
    task automatic start_phase(logic [15:0] rate, logic [15:0] hw, logic [15:0] step,
                               logic [15:0] entries, int send_pct, int recv_pct);
        while (pending_beats.size() != 0 || in_valid || gain_results_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(CFG_ROTATION_RATE, rate);
        write_reg(CFG_HALF_WIDTH, hw);
        write_reg(CFG_ANGLE_STEP, step);
        write_reg(CFG_ENTRIES_IN_USE, entries);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Mostly queries, most aimed into the beam, with ticks, table writes and
    // a little noise
    task automatic random_beats(int n);
        int pick;
        int tgt;
        int cnt;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            cnt  = (cfg_entries > TABLE_DEPTH) ? TABLE_DEPTH : int'(cfg_entries);
            if (cnt == 0)
                cnt = 1;
            if (pick < 45) begin
                tgt = int'(plan_angle) + int'($urandom_range(2 * cfg_hw)) - int'(cfg_hw);
                if (tgt < 0 || tgt > 65535)
                    tgt = $urandom_range(65535);
                queue_query(16'(tgt));
            end else if (pick < 55) begin
                queue_query(16'($urandom));
            end else if (pick < 75) begin
                queue_tick(16'($urandom));
            end else if (pick < 95) begin
                if ($urandom_range(1))
                    queue_write(10'($urandom), 16'($urandom));
                else
                    queue_write(10'($urandom_range(cnt - 1)), 16'($urandom));
            end else begin
                pending_beats.push_back(random_beat(CMD_NONE));
            end
        end
    endtask

    // Sender: present a new beat once the last one is taken, or idle
    always @(negedge i_clk) begin
        if (!in_valid || in_taken) begin
            if (i_rst_n && pending_beats.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                in_data  <= pending_beats.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Hold-off counter: stall the output for a long stretch, once
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Receiver: stall at random, or hold during the hold-off
    always @(negedge i_clk) begin
        out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end

    // Accepted input beat: advance the prediction
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && in_valid && o_in_stall === 1'b0;
        if (i_rst_n && in_valid && o_in_stall === 1'b0)
            gain_results_due.push_back(predict_lookup(in_data));
    end

    // Accepted output beat: compare with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_out_beat due;
        if (i_rst_n && o_out_valid === 1'b1 && !out_stall) begin
            if (gain_results_due.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got %p",
                         $time, o_out_data);
                errors++;
            end else begin
                due = gain_results_due.pop_front();
                if (o_out_data.gain !== due.gain) begin
                    $display("%0t: gain expected %0d got %0d", $time,
                             $signed(due.gain), $signed(o_out_data.gain));
                    errors++;
                end
                if (o_out_data.scan_angle !== due.scan_angle) begin
                    $display("%0t: scan_angle expected %0d got %0d", $time,
                             due.scan_angle, o_out_data.scan_angle);
                    errors++;
                end
                if (o_out_data.in_beam !== due.in_beam) begin
                    $display("%0t: in_beam expected %0b got %0b", $time,
                             due.in_beam, o_out_data.in_beam);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, gain_results_due.size());
            $display("scanning_antenna_gain_lookup_unit: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: full-speed rotation, default beam geometry
        start_phase(16'hFFFF, 16'd8192, 16'd64, 16'd256, 0, 0);
        queue_tick(16'd0);
        queue_tick(16'hFFFF);
        queue_tick(16'd32769);          // wraps past a full turn
        queue_write(10'd0, 16'h8000);
        queue_write(10'd1, 16'h7FFF);
        queue_write(10'd2, 16'd100);
        queue_write(10'd3, 16'd101);
        queue_write(10'd4, 16'd100);
        query_at_offset(0);             // on the lower beam edge: outside
        query_at_offset(1);             // first slot, full-scale swing
        query_at_offset(64);            // exactly on an entry
        query_at_offset(160);           // rising half step rounds up
        query_at_offset(224);           // falling half step rounds toward +inf
        query_at_offset(8192);          // beam center
        query_at_offset(16383);         // last slot lies past the table
        query_at_offset(16384);         // upper beam edge: outside
        queue_query(16'd0);             // far outside the beam
        pending_beats.push_back(random_beat(CMD_NONE));
        queue_write(10'd1023, 16'($urandom));

        // Narrow beam, no idling; masked high bits on the register writes;
        // hold the output long enough to back up the input
        start_phase(16'($urandom), 16'h8200, 16'd16, 16'hF840, 0, 0);
        random_beats(90);
        hold_req = 1'b1;

        // Widest beam with the coarsest step: a single usable slot
        start_phase(16'($urandom), 16'd32767, 16'd32767, 16'd2, 47, 0);
        random_beats(50);

        // Smallest geometry, rotation stopped: every query misses
        start_phase(16'd0, 16'd1, 16'd1, 16'd1, 0, 47);
        random_beats(25);

        // Full table in use
        start_phase(16'($urandom), 16'd32767, 16'd64, 16'd1024, 0, 47);
        random_beats(80);

        // Step written as zero through the masked high bit
        start_phase(16'($urandom), 16'd4000, 16'h8000, 16'd40, 37, 37);
        random_beats(25);

        // Entry count above the table depth, slow rotation
        start_phase(16'd1, 16'd6000, 16'd7, 16'd2047, 37, 37);
        random_beats(90);

        while (pending_beats.size() != 0 || in_valid || gain_results_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d queries (%0d in beam), %0d ticks, %0d table writes",
                 n_queries, n_hits, n_ticks, n_writes);
        $display("and %0d idle commands over 7 register settings, %0d mismatches",
                 n_idle_cmds, errors);
        if (errors == 0)
            $display("scanning_antenna_gain_lookup_unit: match");
        else
            $display("scanning_antenna_gain_lookup_unit: mismatch");
        $finish;
    end

endmodule
